// ===== src/waveform_stats_frequency_macros.svh =====
// assertion macros for the waveform statistics and frequency meter
`ifndef WAVEFORM_STATS_FREQUENCY_MACROS_SVH
`define WAVEFORM_STATS_FREQUENCY_MACROS_SVH
`ifndef SYNTHESIS
`define WSF_ASSERT_IMP(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("wsf assertion failed");
`define WSF_ASSERT_NEXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("wsf assertion failed");
`else
`define WSF_ASSERT_IMP(lbl, ck, rst_n, ante, cons)
`define WSF_ASSERT_NEXT(lbl, ck, rst_n, ante, cons)
`endif
`endif

// ===== src/wsf_pkg.sv =====
// shared types and constants of the waveform statistics and frequency meter
`timescale 1ns / 1ps
package wsf_pkg;
	localparam int SAMPLE_W = 12;
	localparam int RATE_W   = 21;
	localparam int MIN_W    = 16;
	localparam int MEAN_W   = 16;
	localparam int CNT_OUT_W = 11;
	localparam int FREQ_W   = 32;
	localparam int HYST_W   = 10;
	localparam int RECIP5   = 52429;
	localparam int RECIP5_SH = 18;
	localparam int MIN_GAP  = 4;
	localparam int FRAC_Q4  = 4;
	localparam int FRAC_Q8  = 8;
	localparam logic [MIN_W-1:0] MIN_INIT = 16'hFFFF;
	localparam logic [1:0] REG_RATE = 2'd0;
	localparam logic [RATE_W-1:0] RATE_RESET = 21'd20000;

	typedef enum logic [10:0] {
		ST_LOAD  = 11'b000_0000_0001,
		ST_P1    = 11'b000_0000_0010,
		ST_P1W   = 11'b000_0000_0100,
		ST_H1    = 11'b000_0000_1000,
		ST_H2    = 11'b000_0001_0000,
		ST_P2    = 11'b000_0010_0000,
		ST_P2W   = 11'b000_0100_0000,
		ST_MDIV  = 11'b000_1000_0000,
		ST_FSTRT = 11'b001_0000_0000,
		ST_FDIV  = 11'b010_0000_0000,
		ST_FIN   = 11'b100_0000_0000
	} state_t;

	typedef struct packed {
		logic load;
		logic rd_clr;
		logic rd_en;
		logic pass2;
		logic hyst_calc;
		logic hn_calc;
		logic div_start;
		logic div_sel_freq;
		logic mean_cap;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic last_load;
		logic rd_last;
		logic div_busy;
		logic div_done;
	} sts_t;
endpackage

// ===== src/waveform_stats_frequency.sv =====
// waveform statistics and hysteresis crossing frequency meter, top level
`timescale 1ns / 1ps
// usage:
// - input channel (in_valid / in_stall): one sample item per cycle while loading;
//   last_sample ends the capture, so does a full store of CAPTURE_DEPTH samples
// - once a capture ends, in_stall stays high while the block evaluates it
// - evaluation of N stored samples makes two reads of the sample ram per
//   sample, then a one-bit-per-cycle divider run for the mean and another
//   for the frequency, on a divider of DIVW bits with DIVW =
//   max(29 + clog2(CAPTURE_DEPTH+1), 33) (40 at the default depth)
// - output channel (out_valid / out_stall): one result item per capture, held
//   in an output register; a stalled result stays put and the next capture
//   loads meanwhile, only its hand-off waits for the register to free up
// - apb port: sample_rate_hz at address 0, written in the access phase,
//   readable back; pready is tied high
// - reset: capture empty, no result pending, sample rate back to 20000 hz;
//   ram contents are left undefined and only written entries are read
module waveform_stats_frequency #(
	parameter int CAPTURE_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [11:0] sample_value,
	input  logic        last_sample,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] minimum,
	output logic [11:0] maximum,
	output logic [15:0] mean_q4,
	output logic [10:0] valid_count,
	output logic [31:0] frequency_q8,
	output logic        frequency_found
);
	wsf_pkg::cmd_t cmd;
	wsf_pkg::sts_t sts;
	logic [wsf_pkg::RATE_W-1:0] rate_q;

	// config register; the user must write it only while the block is idle, the block does not enforce this
	assign pready = 1'b1;
	assign prdata = (paddr == wsf_pkg::REG_RATE) ? 32'(rate_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= wsf_pkg::RATE_RESET;
		end else if (psel && penable && pwrite && pready && (paddr == wsf_pkg::REG_RATE)) begin
			rate_q <= pwdata[wsf_pkg::RATE_W-1:0];
		end
	end

	wsf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.sts       (sts),
		.cmd       (cmd),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall)
	);

	wsf_datapath #(.CAPTURE_DEPTH(CAPTURE_DEPTH)) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.in_valid        (in_valid),
		.sample_value    (sample_value),
		.last_sample     (last_sample),
		.rate            (rate_q),
		.minimum         (minimum),
		.maximum         (maximum),
		.mean_q4         (mean_q4),
		.valid_count     (valid_count),
		.frequency_q8    (frequency_q8),
		.frequency_found (frequency_found)
	);
endmodule

// ===== src/wsf_ram.sv =====
// generic single-port ram with registered read
`timescale 1ns / 1ps
module wsf_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

// ===== src/wsf_div.sv =====
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module wsf_div #(
	parameter int NUM_W = 40,
	parameter int DEN_W = 11
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic             done,
	output logic [NUM_W-1:0] quot
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DEN_W:0]   shifted;
	logic             fits;

	assign shifted = {rem_q, quo_q[NUM_W-1]};
	assign fits    = shifted >= {1'b0, den_q};
	assign busy    = busy_q;
	assign done    = busy_q && (cnt_q == CNT_W'(NUM_W - 1));
	assign quot    = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= fits ? DEN_W'(shifted - {1'b0, den_q}) : shifted[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end
endmodule

// ===== src/wsf_datapath.sv =====
// capture store, statistics accumulators, crossing tracker and result registers
`timescale 1ns / 1ps
module wsf_datapath #(
	parameter int CAPTURE_DEPTH = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  wsf_pkg::cmd_t                 cmd,
	output wsf_pkg::sts_t                 sts,
	input  logic                          in_valid,
	input  logic [wsf_pkg::SAMPLE_W-1:0]  sample_value,
	input  logic                          last_sample,
	input  logic [wsf_pkg::RATE_W-1:0]    rate,
	output logic [wsf_pkg::MIN_W-1:0]     minimum,
	output logic [wsf_pkg::SAMPLE_W-1:0]  maximum,
	output logic [wsf_pkg::MEAN_W-1:0]    mean_q4,
	output logic [wsf_pkg::CNT_OUT_W-1:0] valid_count,
	output logic [wsf_pkg::FREQ_W-1:0]    frequency_q8,
	output logic                          frequency_found
);
	localparam int SW    = wsf_pkg::SAMPLE_W;
	localparam int AW    = $clog2(CAPTURE_DEPTH);
	localparam int CW    = $clog2(CAPTURE_DEPTH + 1);
	localparam int SUMW  = SW + CW;
	localparam int CMPW  = SUMW + 2;
	localparam int HNW   = wsf_pkg::HYST_W + CW;
	localparam int PRODW = wsf_pkg::RATE_W + CW;
	localparam int NUMW  = PRODW + wsf_pkg::FRAC_Q8;
	localparam int DIVW  = (NUMW > wsf_pkg::FREQ_W + 1) ? NUMW : wsf_pkg::FREQ_W + 1;

	logic             accept;
	logic [CW-1:0]    cnt_q;
	logic [AW-1:0]    rd_addr_q;
	logic [AW-1:0]    ram_addr;
	logic [SW-1:0]    rdata;

	logic             vld_s1;
	logic             p2_s1;
	logic [AW-1:0]    pos_s1;
	logic             vld_s2;
	logic [AW-1:0]    pos_s2;
	logic [SW+CW-1:0] xn_s2;

	logic [CW-1:0]    n_q;
	logic [SUMW-1:0]  sum_q;
	logic [wsf_pkg::MIN_W-1:0] min_q;
	logic [SW-1:0]    max_q;
	logic [wsf_pkg::HYST_W-1:0] hyst_q;
	logic [HNW-1:0]   hn_q;
	logic [CW-1:0]    cross_q;
	logic [CW-1:0]    gap_q;
	logic             above_q;
	logic [AW-1:0]    last_pos_q;
	logic [PRODW-1:0] fprod_q;
	logic [wsf_pkg::MEAN_W-1:0] mean_q;

	logic [SW-1:0]    range_w;
	logic [CMPW-1:0]  two_xn;
	logic [CMPW-1:0]  two_s;
	logic [CMPW-1:0]  hn_ext;
	logic             up_w;
	logic             dn_w;
	logic [AW-1:0]    dist_w;
	logic             found_w;

	logic             div_busy;
	logic             div_done;
	logic [DIVW-1:0]  div_num;
	logic [CW-1:0]    div_den;
	logic [DIVW-1:0]  quot;

	assign accept = cmd.load && in_valid;
	assign ram_addr = accept ? cnt_q[AW-1:0] : rd_addr_q;

	assign sts.last_load = accept && (last_sample || (cnt_q == CW'(CAPTURE_DEPTH - 1)));
	assign sts.rd_last   = CW'(rd_addr_q) == (cnt_q - CW'(1));
	assign sts.div_busy  = div_busy;
	assign sts.div_done  = div_done;

	wsf_ram #(.WIDTH(SW), .DEPTH(CAPTURE_DEPTH)) u_store (
		.clk   (clk),
		.we    (accept),
		.addr  (ram_addr),
		.wdata (sample_value),
		.rdata (rdata)
	);

	// load counter, read address and read valid pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			rd_addr_q <= '0;
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				cnt_q <= '0;
			end else if (accept) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.rd_clr) begin
				rd_addr_q <= '0;
			end else if (cmd.rd_en) begin
				rd_addr_q <= rd_addr_q + AW'(1);
			end
			vld_s1 <= cmd.rd_en;
			vld_s2 <= vld_s1 && p2_s1 && (rdata != '0);
		end
	end

	always_ff @(posedge clk) begin
		p2_s1  <= cmd.pass2;
		pos_s1 <= rd_addr_q;
		pos_s2 <= pos_s1;
		xn_s2  <= rdata * n_q;
	end

	// first pass: min, max, sum, count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q   <= '0;
			sum_q <= '0;
			min_q <= wsf_pkg::MIN_INIT;
			max_q <= '0;
		end else if (cmd.load) begin
			n_q   <= '0;
			sum_q <= '0;
			min_q <= wsf_pkg::MIN_INIT;
			max_q <= '0;
		end else if (vld_s1 && !p2_s1 && (rdata != '0)) begin
			n_q   <= n_q + CW'(1);
			sum_q <= sum_q + SUMW'(rdata);
			if (wsf_pkg::MIN_W'(rdata) < min_q) begin
				min_q <= wsf_pkg::MIN_W'(rdata);
			end
			if (rdata > max_q) begin
				max_q <= rdata;
			end
		end
	end

	// hysteresis = range / 5 by reciprocal, then hyst * n; also the mean and the rate * (crossings - 1) product
	assign range_w = (wsf_pkg::MIN_W'(max_q) > min_q) ? SW'(wsf_pkg::MIN_W'(max_q) - min_q) : '0;

	always_ff @(posedge clk) begin
		if (cmd.hyst_calc) begin
			hyst_q <= wsf_pkg::HYST_W'((32'(range_w) * 32'(wsf_pkg::RECIP5)) >> wsf_pkg::RECIP5_SH);
		end
		if (cmd.hn_calc) begin
			hn_q <= hyst_q * n_q;
		end
		if (cmd.mean_cap) begin
			mean_q <= (n_q == '0) ? '0 :
				((|quot[DIVW-1:wsf_pkg::MEAN_W]) ? '1 : quot[wsf_pkg::MEAN_W-1:0]);
		end
		fprod_q <= rate * (cross_q - CW'(1));
	end

	// second pass: band compare and crossing bookkeeping
	assign two_xn = CMPW'({xn_s2, 1'b0});
	assign two_s  = CMPW'({sum_q, 1'b0});
	assign hn_ext = CMPW'(hn_q);
	assign up_w   = two_xn > (two_s + hn_ext);
	assign dn_w   = (two_xn + hn_ext) < two_s;
	assign dist_w = pos_s2 - last_pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cross_q    <= '0;
			gap_q      <= '0;
			above_q    <= 1'b0;
			last_pos_q <= '0;
		end else if (cmd.hyst_calc) begin
			cross_q    <= '0;
			gap_q      <= '0;
			above_q    <= 1'b0;
			last_pos_q <= '0;
		end else if (vld_s2) begin
			if (!above_q && up_w) begin
				above_q    <= 1'b1;
				last_pos_q <= pos_s2;
				cross_q    <= cross_q + CW'(1);
				if ((cross_q != '0) && (32'(dist_w) >= 32'(wsf_pkg::MIN_GAP))) begin
					gap_q <= gap_q + CW'(dist_w);
				end
			end else if (above_q && dn_w) begin
				above_q <= 1'b0;
			end
		end
	end

	// shared divider: mean first, then frequency
	assign div_num = cmd.div_sel_freq ? DIVW'({fprod_q, 8'd0}) :
		DIVW'({sum_q, 4'd0});
	assign div_den = cmd.div_sel_freq ? gap_q : n_q;

	wsf_div #(.NUM_W(DIVW), .DEN_W(CW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.done   (div_done),
		.quot   (quot)
	);

	assign found_w = (cross_q > CW'(1)) && (gap_q != '0);

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			minimum         <= min_q;
			maximum         <= max_q;
			mean_q4         <= mean_q;
			valid_count     <= wsf_pkg::CNT_OUT_W'(n_q);
			frequency_found <= found_w;
			frequency_q8    <= !found_w ? '0 :
				((|quot[DIVW-1:wsf_pkg::FREQ_W]) ? '1 : quot[wsf_pkg::FREQ_W-1:0]);
		end
	end
endmodule

// ===== src/wsf_ctrl.sv =====
// sequencing state machine for load, two passes, divisions and result hand-off
`timescale 1ns / 1ps
`include "waveform_stats_frequency_macros.svh"
module wsf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  wsf_pkg::sts_t sts,
	output wsf_pkg::cmd_t cmd,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall
);
	wsf_pkg::state_t state_q, state_d;
	logic drain_q;
	logic out_valid_q;
	logic out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = state_q != wsf_pkg::ST_LOAD;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.load         = state_q == wsf_pkg::ST_LOAD;
		cmd.rd_clr       = (state_q == wsf_pkg::ST_LOAD) || (state_q == wsf_pkg::ST_H1);
		cmd.rd_en        = (state_q == wsf_pkg::ST_P1) || (state_q == wsf_pkg::ST_P2);
		cmd.pass2        = (state_q == wsf_pkg::ST_P2) || (state_q == wsf_pkg::ST_P2W);
		cmd.hyst_calc    = state_q == wsf_pkg::ST_H1;
		cmd.hn_calc      = state_q == wsf_pkg::ST_H2;
		cmd.div_sel_freq = state_q == wsf_pkg::ST_FSTRT;
		cmd.div_start    = ((state_q == wsf_pkg::ST_P2W) && !drain_q) ||
			(state_q == wsf_pkg::ST_FSTRT);
		cmd.mean_cap     = state_q == wsf_pkg::ST_FSTRT;
		cmd.out_load     = (state_q == wsf_pkg::ST_FIN) && out_free;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wsf_pkg::ST_LOAD:  if (sts.last_load) state_d = wsf_pkg::ST_P1;
			wsf_pkg::ST_P1:    if (sts.rd_last) state_d = wsf_pkg::ST_P1W;
			wsf_pkg::ST_P1W:   if (!drain_q) state_d = wsf_pkg::ST_H1;
			wsf_pkg::ST_H1:    state_d = wsf_pkg::ST_H2;
			wsf_pkg::ST_H2:    state_d = wsf_pkg::ST_P2;
			wsf_pkg::ST_P2:    if (sts.rd_last) state_d = wsf_pkg::ST_P2W;
			wsf_pkg::ST_P2W:   if (!drain_q) state_d = wsf_pkg::ST_MDIV;
			wsf_pkg::ST_MDIV:  if (sts.div_done) state_d = wsf_pkg::ST_FSTRT;
			wsf_pkg::ST_FSTRT: state_d = wsf_pkg::ST_FDIV;
			wsf_pkg::ST_FDIV:  if (sts.div_done) state_d = wsf_pkg::ST_FIN;
			wsf_pkg::ST_FIN:   if (out_free) state_d = wsf_pkg::ST_LOAD;
			default:           state_d = wsf_pkg::ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wsf_pkg::ST_LOAD;
			drain_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// drain_q, set after each read pass, holds the wait state so the read pipeline can empty
			if ((state_q == wsf_pkg::ST_P1) || (state_q == wsf_pkg::ST_P2)) begin
				drain_q <= 1'b1;
			end else begin
				drain_q <= 1'b0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`WSF_ASSERT_IMP(a_stall_outside_load, clk, arst_n, !in_stall, state_q == wsf_pkg::ST_LOAD)
	`WSF_ASSERT_IMP(a_div_start_idle, clk, arst_n, cmd.div_start, !sts.div_busy)
	`WSF_ASSERT_IMP(a_out_load_free, clk, arst_n, cmd.out_load, !out_valid_q || !out_stall)
	`WSF_ASSERT_NEXT(a_last_starts_pass, clk, arst_n, cmd.load && sts.last_load,
		state_q == wsf_pkg::ST_P1)
endmodule

// ===== bench/waveform_stats_frequency_tb.sv =====
// testbench for the waveform statistics and frequency meter
`timescale 1ns / 1ps
module waveform_stats_frequency_tb;
	localparam int DEPTH = 1024;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic [15:0] minimum;
		logic [11:0] maximum;
		logic [15:0] mean_q4;
		logic [10:0] valid_count;
		logic [31:0] frequency_q8;
		logic        frequency_found;
	} capture_stats_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [1:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [11:0] sample_value = '0;
	logic        last_sample = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] minimum;
	logic [11:0] maximum;
	logic [15:0] mean_q4;
	logic [10:0] valid_count;
	logic [31:0] frequency_q8;
	logic        frequency_found;

	// predictor state: rate register and the capture loaded so far
	logic [wsf_pkg::RATE_W-1:0] rate_hz = wsf_pkg::RATE_RESET;
	logic [11:0] capture_buf [DEPTH];
	int unsigned capture_len = 0;
	capture_stats_t stats_due [$];

	int unsigned fail_count = 0;
	longint unsigned cycle_count = 0;
	bit idle_off = 1'b0;        // suppresses random gaps on both sides
	bit hold_results = 1'b0;    // long receiver hold-off in progress

	always #6 clk = ~clk;

	waveform_stats_frequency u_top (.*);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("waveform_stats_frequency verification failed");
			$finish;
		end
	end

	// evaluates one finished capture the way the block must
	function automatic capture_stats_t capture_eval();
		capture_stats_t r;
		longint unsigned s, n, lo, hi, hyst, two_s, hn, two_xn, f;
		longint unsigned crossings, gaps, prev_pos;
		bit above;
		s = 0; n = 0; lo = 65535; hi = 0;
		crossings = 0; gaps = 0; prev_pos = 0; above = 0; f = 0;
		r = '0;
		for (int i = 0; i < capture_len; i++) begin
			if (capture_buf[i] != 0) begin
				if (capture_buf[i] < lo) lo = capture_buf[i];
				if (capture_buf[i] > hi) hi = capture_buf[i];
				s += capture_buf[i];
				n++;
			end
		end
		r.minimum = lo[15:0];
		r.maximum = hi[11:0];
		r.valid_count = n[10:0];
		if (n > 0) begin
			hyst = (hi > lo) ? (hi - lo) / 5 : 0;
			two_s = 2 * s;
			hn = hyst * n;
			r.mean_q4 = ((s * 16) / n > 65535) ? 16'hFFFF : 16'((s * 16) / n);
			for (int i = 0; i < capture_len; i++) begin
				if (capture_buf[i] == 0) continue;
				two_xn = 2 * longint'(capture_buf[i]) * n;
				if (!above && two_xn > two_s + hn) begin
					above = 1;
					if (crossings > 0 && i - prev_pos >= wsf_pkg::MIN_GAP)
						gaps += i - prev_pos;
					prev_pos = i;
					crossings++;
				end else if (above && two_xn + hn < two_s) begin
					above = 0;
				end
			end
			if (crossings > 1 && gaps > 0) begin
				r.frequency_found = 1'b1;
				f = (longint'(rate_hz) * (crossings - 1) * 256) / gaps;
				r.frequency_q8 = (f > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : f[31:0];
			end
		end
		return r;
	endfunction

	// offers one sample item and folds it into the prediction once accepted
	task automatic send_sample(input logic [11:0] v, input bit lst);
		while (!idle_off && $urandom_range(99) < 28) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample_value <= v;
		last_sample <= lst;
		do @(posedge clk); while (in_stall);
		capture_buf[capture_len] = v;
		capture_len++;
		if (lst || capture_len >= DEPTH) begin
			stats_due.push_back(capture_eval());
			capture_len = 0;
		end
	endtask

	// random receiver stalls, or a solid hold-off while hold_results is set
	always @(posedge clk) begin
		if (hold_results) out_stall <= 1'b1;
		else out_stall <= !idle_off && ($urandom_range(99) < 28);
	end

	// compares each accepted result with the oldest prediction
	always @(posedge clk) begin
		capture_stats_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = {minimum, maximum, mean_q4, valid_count, frequency_q8, frequency_found};
			if (stats_due.size() == 0) begin
				$display("%0t: unexpected result %p", $time, got);
				fail_count++;
			end else begin
				want = stats_due.pop_front();
				if (got.minimum !== want.minimum) begin
					$display("%0t: minimum exp %0d got %0d", $time, want.minimum, got.minimum);
					fail_count++;
				end
				if (got.maximum !== want.maximum) begin
					$display("%0t: maximum exp %0d got %0d", $time, want.maximum, got.maximum);
					fail_count++;
				end
				if (got.mean_q4 !== want.mean_q4) begin
					$display("%0t: mean_q4 exp %0d got %0d", $time, want.mean_q4, got.mean_q4);
					fail_count++;
				end
				if (got.valid_count !== want.valid_count) begin
					$display("%0t: valid_count exp %0d got %0d", $time, want.valid_count,
						got.valid_count);
					fail_count++;
				end
				if (got.frequency_q8 !== want.frequency_q8) begin
					$display("%0t: frequency_q8 exp %0d got %0d", $time, want.frequency_q8,
						got.frequency_q8);
					fail_count++;
				end
				if (got.frequency_found !== want.frequency_found) begin
					$display("%0t: frequency_found exp %0d got %0d", $time,
						want.frequency_found, got.frequency_found);
					fail_count++;
				end
			end
		end
	end

	// waits until every predicted result is out and the block has settled
	task automatic drain();
		in_valid <= 1'b0;
		while (stats_due.size() != 0) @(posedge clk);
		repeat (2 * DEPTH + 120) @(posedge clk);
	endtask

	task automatic write_rate(input logic [wsf_pkg::RATE_W-1:0] v);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= wsf_pkg::REG_RATE; pwdata <= 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		rate_hz = v;
	endtask

	// one capture of a square-ish wave with given period, random noise and a given share of zero samples
	task automatic send_wave(input int len, input int period, input int zero_pct);
		logic [11:0] lvl_lo, lvl_hi, v;
		lvl_lo = 12'($urandom_range(1, 1500));
		lvl_hi = 12'($urandom_range(2500, 4095));
		for (int i = 0; i < len; i++) begin
			v = ((i % period) < period / 2) ? lvl_hi : lvl_lo;
			v = v ^ 12'($urandom_range(0, 63));
			if ($urandom_range(99) < zero_pct) v = 0;
			send_sample(v, i == len - 1);
		end
	endtask

	task automatic test_directed();
		// single sample, all zero capture, extremes of the sample field
		send_sample(12'd0, 1'b1);
		send_sample(12'hFFF, 1'b1);
		send_sample(12'd1, 1'b0);
		send_sample(12'hFFF, 1'b0);
		send_sample(12'd0, 1'b1);
		send_sample(12'hAAA, 1'b0);
		send_sample(12'h555, 1'b1);
		// two crossings close together add no gap
		send_sample(12'd10, 1'b0);
		send_sample(12'd4000, 1'b0);
		send_sample(12'd10, 1'b0);
		send_sample(12'd4000, 1'b1);
		// clean wave that yields a frequency
		send_wave(14, 6, 0);
		drain();
	endtask

	task automatic test_full_store();
		// capture ends on a full store without a last flag
		for (int i = 0; i < DEPTH; i++)
			send_sample(((i % 16) < 8) ? 12'd3900 : 12'd200, 1'b0);
		drain();
	endtask

	task automatic test_rates();
		logic [wsf_pkg::RATE_W-1:0] rates [5] =
			'{21'd1, 21'd2000000, 21'd0, 21'h1FFFFF, 21'd48000};
		foreach (rates[k]) begin
			write_rate(rates[k]);
			send_wave(24, 8, 5);
			send_wave(40, 5, 0);
			drain();
		end
	endtask

	task automatic test_backpressure();
		// receiver holds off while captures keep coming
		hold_results = 1'b1;
		fork
			begin
				for (int c = 0; c < 4; c++) send_wave(8, 4, 0);
			end
			begin
				repeat (600) @(posedge clk);
				hold_results = 1'b0;
			end
		join
		drain();
	endtask

	task automatic test_random();
		int sent;
		int len;
		sent = 0;
		while (sent < 300) begin
			len = $urandom_range(2, 60);
			idle_off = (sent > 100 && sent < 200);
			case ($urandom_range(9))
				0: for (int i = 0; i < len; i++)
					send_sample(12'($urandom), i == len - 1 || $urandom_range(40) == 0);
				1: begin
					// rate changes only with no capture open and no result pending
					if (capture_len != 0) send_sample(12'($urandom), 1'b1);
					drain();
					write_rate(wsf_pkg::RATE_W'($urandom_range(0, 2000000)));
					send_wave(len, $urandom_range(2, 12), 0);
					drain();
				end
				default: send_wave(len, $urandom_range(2, 16), $urandom_range(0, 20));
			endcase
			sent += len;
		end
		idle_off = 1'b0;
		// close any open capture
		if (capture_len != 0) send_sample(12'($urandom), 1'b1);
		drain();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_store();
		test_rates();
		test_backpressure();
		test_random();
		if (fail_count == 0) $display("waveform_stats_frequency verification clean");
		else $display("waveform_stats_frequency verification failed");
		$finish;
	end
endmodule
